@@ design/i2cmts_pkg.sv @@
// ----------------------------------------------------------------------------
// i2cmts_pkg
// Types, bus status codes and sizes shared by the I2C master transfer
// sequencer.
// ----------------------------------------------------------------------------
package i2cmts_pkg;

  // Depth of the write-byte store and the width of an index into it.
  localparam int WRITE_DEPTH = 16;
  localparam int WR_IDX_W    = $clog2(WRITE_DEPTH);

  // Item kinds.
  localparam logic [1:0] KIND_START = 2'd0;
  localparam logic [1:0] KIND_LOAD  = 2'd1;
  localparam logic [1:0] KIND_EVENT = 2'd2;

  // Status codes reported by the bus engine.
  localparam logic [7:0] BUS_START       = 8'h08;
  localparam logic [7:0] BUS_RESTART     = 8'h10;
  localparam logic [7:0] BUS_SLA_W_ACK   = 8'h18;
  localparam logic [7:0] BUS_SLA_W_NACK  = 8'h20;
  localparam logic [7:0] BUS_DATA_W_ACK  = 8'h28;
  localparam logic [7:0] BUS_DATA_W_NACK = 8'h30;
  localparam logic [7:0] BUS_ARB_LOST    = 8'h38;
  localparam logic [7:0] BUS_SLA_R_ACK   = 8'h40;
  localparam logic [7:0] BUS_SLA_R_NACK  = 8'h48;
  localparam logic [7:0] BUS_DATA_R_ACK  = 8'h50;
  localparam logic [7:0] BUS_DATA_R_NACK = 8'h58;

  // Direction bit of the address byte that selects a read.
  localparam logic [7:0] ADDR_READ_BIT = 8'h01;

  // Transfer status codes.
  typedef enum logic [2:0] {
    TS_IDLE      = 3'd0,
    TS_OK        = 3'd1,
    TS_NO_DATA   = 3'd2,
    TS_NACK_DATA = 3'd3,
    TS_NACK_ADDR = 3'd4,
    TS_ARB_LOST  = 3'd5
  } xfer_status_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] slave_addr;
    logic [4:0] tx_count;
    logic [7:0] rx_count;
    logic [3:0] load_index;
    logic [7:0] load_byte;
    logic [7:0] bus_status;
    logic [7:0] bus_data;
  } in_item_t;

  typedef struct packed {
    logic       data_valid;
    logic [7:0] data_out;
    logic       clear_start;
    logic       set_start;
    logic       set_stop;
    logic       ack_valid;
    logic       ack_assert;
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic [7:0] rx_index;
    logic [2:0] status;
    logic       done_res;
  } out_item_t;

  // Write port of the write-byte store.
  typedef struct packed {
    logic                en;
    logic [WR_IDX_W-1:0] idx;
    logic [7:0]          data;
  } wstore_wr_t;

endpackage

@@ design/i2cmts_wstore.sv @@
// ----------------------------------------------------------------------------
// i2cmts_wstore
// Write-byte store: one write port, one asynchronous read port.
// ----------------------------------------------------------------------------
module i2cmts_wstore
  import i2cmts_pkg::*;
(
  input  logic                clk,
  input  wstore_wr_t          wr,
  input  logic [WR_IDX_W-1:0] rd_idx,
  output logic [7:0]          rd_data
);

  // Contents are undefined until written, so the array has no reset.
  logic [7:0] mem_r [WRITE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem_r[wr.idx] <= wr.data;
    end
  end

  assign rd_data = mem_r[rd_idx];

endmodule

@@ design/i2cmts_ctrl.sv @@
// ----------------------------------------------------------------------------
// i2cmts_ctrl
// Transfer state registers and the single-step decode of one item.
// ----------------------------------------------------------------------------
module i2cmts_ctrl
  import i2cmts_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  in_item_t            item,
  input  logic [7:0]          store_rd_data,
  output logic [WR_IDX_W-1:0] store_rd_idx,
  output wstore_wr_t          store_wr,
  output out_item_t           result
);

  logic [7:0]   addr_r, addr_nxt;
  logic [4:0]   wlen_r, wlen_nxt;
  logic [7:0]   rlen_r, rlen_nxt;
  logic [4:0]   wpos_r, wpos_nxt;
  logic [7:0]   rpos_r, rpos_nxt;
  xfer_status_t xst_r, xst_nxt;

  logic         more_writes;
  logic [8:0]   ack_pos;

  assign more_writes  = (wpos_r < wlen_r);
  assign store_rd_idx = wpos_r[WR_IDX_W-1:0];

  assign store_wr.en   = step && (item.kind == KIND_LOAD);
  assign store_wr.idx  = item.load_index[WR_IDX_W-1:0];
  assign store_wr.data = item.load_byte;

  always_comb begin
    addr_nxt = addr_r;
    wlen_nxt = wlen_r;
    rlen_nxt = rlen_r;
    wpos_nxt = wpos_r;
    rpos_nxt = rpos_r;
    xst_nxt  = xst_r;
    ack_pos  = '0;
    result   = '0;

    case (item.kind)
      KIND_START: begin
        addr_nxt = item.slave_addr;
        wlen_nxt = (item.tx_count > 5'(WRITE_DEPTH)) ? 5'(WRITE_DEPTH) : item.tx_count;
        rlen_nxt = item.rx_count;
        wpos_nxt = '0;
        rpos_nxt = '0;
        xst_nxt  = TS_IDLE;
        result.set_start = 1'b1;
      end
      KIND_EVENT: begin
        unique case (item.bus_status)
          BUS_START: begin
            wpos_nxt = '0;
            result.data_valid  = 1'b1;
            result.data_out    = (wlen_r == '0) ? (addr_r | ADDR_READ_BIT) : addr_r;
            result.clear_start = 1'b1;
          end
          BUS_RESTART: begin
            rpos_nxt = '0;
            result.data_valid  = 1'b1;
            result.data_out    = more_writes ? addr_r : (addr_r | ADDR_READ_BIT);
            result.clear_start = 1'b1;
          end
          BUS_SLA_W_ACK: begin
            if (wlen_r == '0) begin
              xst_nxt = TS_NO_DATA;
              result.set_stop    = 1'b1;
              result.clear_start = 1'b1;
              result.done_res    = 1'b1;
            end else if (more_writes) begin
              result.data_valid = 1'b1;
              result.data_out   = store_rd_data;
              wpos_nxt          = wpos_r + 5'd1;
            end
          end
          BUS_DATA_W_ACK: begin
            if (more_writes) begin
              result.data_valid = 1'b1;
              result.data_out   = store_rd_data;
              wpos_nxt          = wpos_r + 5'd1;
            end else if (rlen_r != '0) begin
              rpos_nxt         = '0;
              result.set_start = 1'b1;
            end else begin
              xst_nxt = TS_OK;
              result.set_stop    = 1'b1;
              result.clear_start = 1'b1;
              result.done_res    = 1'b1;
            end
          end
          BUS_DATA_W_NACK: begin
            xst_nxt = TS_NACK_DATA;
            result.set_stop    = 1'b1;
            result.clear_start = 1'b1;
            result.done_res    = 1'b1;
          end
          BUS_SLA_R_ACK: begin
            ack_pos = {1'b0, rpos_r} + 9'd1;
            result.ack_valid  = 1'b1;
            result.ack_assert = (ack_pos < {1'b0, rlen_r});
          end
          BUS_DATA_R_ACK: begin
            // A byte beyond the read count is dropped and the position held.
            if (rpos_r < rlen_r) begin
              result.rx_valid = 1'b1;
              result.rx_byte  = item.bus_data;
              result.rx_index = rpos_r;
              rpos_nxt        = rpos_r + 8'd1;
            end
            ack_pos = {1'b0, rpos_nxt} + 9'd1;
            result.ack_valid  = 1'b1;
            result.ack_assert = (ack_pos < {1'b0, rlen_r});
          end
          BUS_DATA_R_NACK: begin
            if (rpos_r < rlen_r) begin
              result.rx_valid = 1'b1;
              result.rx_byte  = item.bus_data;
              result.rx_index = rpos_r;
              rpos_nxt        = rpos_r + 8'd1;
            end
            xst_nxt = TS_OK;
            result.set_stop    = 1'b1;
            result.clear_start = 1'b1;
            result.done_res    = 1'b1;
          end
          BUS_SLA_W_NACK, BUS_SLA_R_NACK: begin
            xst_nxt = TS_NACK_ADDR;
            result.set_stop    = 1'b1;
            result.clear_start = 1'b1;
            result.done_res    = 1'b1;
          end
          default: begin
            // Lost arbitration, and any code the sequencer does not know.
            xst_nxt = TS_ARB_LOST;
            result.clear_start = 1'b1;
            result.done_res    = 1'b1;
          end
        endcase
      end
      default: begin
      end
    endcase

    result.status = xst_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r <= '0;
      wlen_r <= '0;
      rlen_r <= '0;
      wpos_r <= '0;
      rpos_r <= '0;
      xst_r  <= TS_IDLE;
    end else if (step) begin
      addr_r <= addr_nxt;
      wlen_r <= wlen_nxt;
      rlen_r <= rlen_nxt;
      wpos_r <= wpos_nxt;
      rpos_r <= rpos_nxt;
      xst_r  <= xst_nxt;
    end
  end

endmodule

@@ design/i2c_master_transfer_sequencer.sv @@
// ----------------------------------------------------------------------------
// i2c_master_transfer_sequencer
// Master-side sequencer of an I2C transfer, one result per transaction.
//
// Every accepted input transaction yields exactly one result transaction.
// The block takes one transaction per clock cycle while the output side is
// not stalled: a transaction is held in the input register until it can be
// decoded, is decoded against the transfer state in a single combinational
// step, and its result is captured in the output register, from which it is
// presented. The input side keeps accepting while a result waits to be
// taken, as long as the decode step has somewhere to put its result.
// A start transaction captures the address byte and the write and read
// counts and asks for START; load transactions fill the sixteen-byte write
// store, whose entries must be written before the transfer reads them; bus
// status events choose the next byte to send, repeated START or STOP, the
// ACK or NACK for the next received byte, and report each received byte
// with its index and the transfer status.
// ----------------------------------------------------------------------------
module i2c_master_transfer_sequencer
  import i2cmts_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  // Input register stage.
  logic      in_vld_r;
  in_item_t  in_item_r;

  // Output register stage.
  logic      out_vld_r;
  out_item_t out_item_r;

  logic                step;
  out_item_t           step_result;
  logic [WR_IDX_W-1:0] store_rd_idx;
  logic [7:0]          store_rd_data;
  wstore_wr_t          store_wr;

  // The held transaction is decoded when the output register is empty or is
  // being emptied in this cycle; the state then advances with it.
  assign step     = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_item_r <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (step) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_item_r <= step_result;
    end
  end

  i2cmts_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (step),
    .item         (in_item_r),
    .store_rd_data(store_rd_data),
    .store_rd_idx (store_rd_idx),
    .store_wr     (store_wr),
    .result       (step_result)
  );

  i2cmts_wstore u_wstore (
    .clk    (clk),
    .wr     (store_wr),
    .rd_idx (store_rd_idx),
    .rd_data(store_rd_data)
  );

  assign out_valid = out_vld_r;
  assign out_item  = out_item_r;

endmodule

@@ bench/tb_i2c_master_transfer_sequencer.sv @@
// ----------------------------------------------------------------------------
// tb_i2c_master_transfer_sequencer
// Self-checking bench for the I2C master transfer sequencer. A directed
// opening covers the corner cases of each bus status code. It is followed by
// random, mostly well-formed transfers with some noise mixed in. Every
// accepted transaction is run through a behavioural predictor, and each
// result transaction is checked field by field against the oldest
// prediction. Both handshakes see random gaps.
// ----------------------------------------------------------------------------
module tb_i2c_master_transfer_sequencer;
  import i2cmts_pkg::*;

  // Minimum number of random input transactions to generate after the directed part.
  localparam int STIM_ITEMS  = 1800;
  // Cycles without any handshake before the run is declared hung. The worst
  // honest quiet spell is a long sender gap plus a long receiver stall plus
  // the pipeline.
  localparam int STALL_LIMIT = 1000;
  // Cycles to keep watching the result port once everything has arrived.
  localparam int TAIL_CYCLES = 20;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_item   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;

  i2c_master_transfer_sequencer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Transfer predictor.
  // These variables mirror the sequencer's own state. They start at the
  // reset values, and reset is applied only once, so no re-initialisation
  // is needed.
  // --------------------------------------------------------------------------
  logic [7:0]   seq_addr   = '0;
  logic [4:0]   seq_wr_len = '0;
  logic [7:0]   seq_rd_len = '0;
  logic [4:0]   seq_wr_pos = '0;
  logic [7:0]   seq_rd_pos = '0;
  logic [7:0]   seq_store [WRITE_DEPTH];
  xfer_status_t seq_state  = TS_IDLE;

  // The address goes out with the read bit set once the write phase is over.
  function automatic void send_addr(inout out_item_t r);
    r.data_valid = 1'b1;
    r.data_out   = seq_addr;
    if (seq_wr_pos >= seq_wr_len) r.data_out = seq_addr | ADDR_READ_BIT;
  endfunction

  // Callers only reach this with the write position below the write length,
  // and that length never exceeds the store depth, so the entry is in range.
  function automatic void send_wr_byte(inout out_item_t r);
    r.data_valid = 1'b1;
    r.data_out   = (seq_wr_pos < seq_wr_len) ? seq_store[seq_wr_pos[3:0]] : 8'h00;
    seq_wr_pos   = seq_wr_pos + 5'd1;
  endfunction

  // ACK while at least one more byte is wanted after the next one, else NACK.
  function automatic void ack_next(inout out_item_t r);
    r.ack_valid  = 1'b1;
    r.ack_assert = ({1'b0, seq_rd_pos} + 9'd1) < {1'b0, seq_rd_len};
  endfunction

  // A byte that arrives past the read length is dropped without a trace.
  function automatic void take_rx(inout out_item_t r, input logic [7:0] b);
    if (seq_rd_pos < seq_rd_len) begin
      r.rx_valid = 1'b1;
      r.rx_byte  = b;
      r.rx_index = seq_rd_pos;
      seq_rd_pos = seq_rd_pos + 8'd1;
    end
  endfunction

  function automatic void end_xfer(inout out_item_t r, input xfer_status_t st,
                                   input logic stop);
    seq_state     = st;
    r.set_stop    = stop;
    r.clear_start = 1'b1;
    r.done_res    = 1'b1;
  endfunction

  function automatic out_item_t transfer_actions(in_item_t it);
    out_item_t r;
    r = '0;
    case (it.kind)
      KIND_START: begin
        // Write counts beyond the store depth are clipped to the depth.
        seq_wr_len = (it.tx_count > 5'(WRITE_DEPTH)) ? 5'(WRITE_DEPTH) : it.tx_count;
        seq_addr   = it.slave_addr;
        seq_rd_len = it.rx_count;
        seq_wr_pos = '0;
        seq_rd_pos = '0;
        seq_state  = TS_IDLE;
        r.set_start = 1'b1;
      end
      // The index field is exactly as wide as the store, so every load lands.
      KIND_LOAD: seq_store[it.load_index] = it.load_byte;
      KIND_EVENT: begin
        case (it.bus_status)
          BUS_START: begin
            seq_wr_pos = '0;
            send_addr(r);
            r.clear_start = 1'b1;
          end
          BUS_RESTART: begin
            seq_rd_pos = '0;
            send_addr(r);
            r.clear_start = 1'b1;
          end
          BUS_SLA_W_ACK: begin
            // An ACK with all bytes already sent is spurious and ignored.
            if (seq_wr_len == '0) end_xfer(r, TS_NO_DATA, 1'b1);
            else if (seq_wr_pos < seq_wr_len) send_wr_byte(r);
          end
          BUS_DATA_W_ACK: begin
            if (seq_wr_pos < seq_wr_len) begin
              send_wr_byte(r);
            end else if (seq_rd_len != '0) begin
              seq_rd_pos  = '0;
              r.set_start = 1'b1;
            end else begin
              end_xfer(r, TS_OK, 1'b1);
            end
          end
          BUS_DATA_W_NACK: end_xfer(r, TS_NACK_DATA, 1'b1);
          BUS_SLA_R_ACK:   ack_next(r);
          BUS_DATA_R_ACK: begin
            take_rx(r, it.bus_data);
            ack_next(r);
          end
          BUS_DATA_R_NACK: begin
            take_rx(r, it.bus_data);
            end_xfer(r, TS_OK, 1'b1);
          end
          BUS_SLA_W_NACK, BUS_SLA_R_NACK: end_xfer(r, TS_NACK_ADDR, 1'b1);
          // Lost arbitration, and any code the engine should never report.
          default: end_xfer(r, TS_ARB_LOST, 1'b0);
        endcase
      end
      default: ;
    endcase
    r.status = seq_state;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus store and bookkeeping.
  // pending_hold marks transactions that may only be offered once every
  // expected result has been collected.
  // --------------------------------------------------------------------------
  in_item_t  pending_items[$];
  bit        pending_hold[$];
  out_item_t awaited_results[$];

  bit store_written [WRITE_DEPTH];
  bit hold_next;
  bit in_taken;
  int stim_total;
  int accepted_total;
  int mismatches;
  int idle_cycles;
  int in_gap, in_calm, out_gap, out_calm;

  function automatic bit one_in(int n);
    return $urandom_range(n - 1) == 0;
  endfunction

  // Every field is filled at random, so that the fields a kind ignores still
  // see both values on every bit.
  function automatic in_item_t any_item();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return raw[$bits(in_item_t)-1:0];
  endfunction

  task automatic push_item(in_item_t it);
    pending_items.push_back(it);
    pending_hold.push_back(hold_next);
    hold_next = 1'b0;
  endtask

  task automatic add_load(logic [3:0] idx, logic [7:0] b);
    in_item_t it;
    it = any_item();
    it.kind       = KIND_LOAD;
    it.load_index = idx;
    it.load_byte  = b;
    store_written[idx] = 1'b1;
    push_item(it);
  endtask

  // With preload set, every store entry that the transfer could read is
  // loaded beforehand, so that no never-written entry is ever sent on the bus.
  task automatic add_start(logic [7:0] addr, logic [4:0] tx, logic [7:0] rx,
                           bit preload);
    in_item_t it;
    if (preload)
      for (int i = 0; i < WRITE_DEPTH && i < tx; i++)
        if (!store_written[i]) add_load(4'(i), 8'($urandom_range(255)));
    it = any_item();
    it.kind       = KIND_START;
    it.slave_addr = addr;
    it.tx_count   = tx;
    it.rx_count   = rx;
    push_item(it);
  endtask

  task automatic add_event(logic [7:0] code, logic [7:0] b);
    in_item_t it;
    it = any_item();
    it.kind       = KIND_EVENT;
    it.bus_status = code;
    it.bus_data   = b;
    push_item(it);
  endtask

  // One transfer as the bus engine would report it. It is occasionally cut
  // short by a NACK or by lost arbitration. Write and read lengths are
  // mostly small, and the full read length is used only rarely.
  task automatic add_transfer();
    int tx, rx, wl, pick;
    pick = $urandom_range(99);
    if (pick < 70)      tx = $urandom_range(4);
    else if (pick < 92) tx = $urandom_range(16);
    else                tx = $urandom_range(31);
    wl = (tx > WRITE_DEPTH) ? WRITE_DEPTH : tx;
    pick = $urandom_range(99);
    if (pick < 75)      rx = $urandom_range(5);
    else if (pick < 99) rx = $urandom_range(6, 24);
    else                rx = $urandom_range(200, 255);

    if (one_in(3)) add_load(4'($urandom_range(15)), 8'($urandom_range(255)));
    if (one_in(40)) hold_next = 1'b1;
    add_start(8'($urandom_range(255)), 5'(tx), 8'(rx), 1'b1);
    add_event(BUS_START, 8'($urandom_range(255)));

    if (wl > 0) begin
      if (one_in(25)) begin
        add_event(BUS_SLA_W_NACK, 8'($urandom_range(255)));
        return;
      end
      add_event(BUS_SLA_W_ACK, 8'($urandom_range(255)));
      // The address ACK sends the first byte. Each data ACK sends the next
      // one, and the last data ACK moves on to the read part or to STOP.
      for (int i = 0; i < wl; i++) begin
        if (one_in(40)) begin
          add_event(BUS_DATA_W_NACK, 8'($urandom_range(255)));
          return;
        end
        if (one_in(80)) begin
          add_event(BUS_ARB_LOST, 8'($urandom_range(255)));
          return;
        end
        if (one_in(60)) add_load(4'($urandom_range(15)), 8'($urandom_range(255)));
        add_event(BUS_DATA_W_ACK, 8'($urandom_range(255)));
      end
      if (rx == 0) return;
      add_event(BUS_RESTART, 8'($urandom_range(255)));
    end else if (rx == 0) begin
      add_event(BUS_SLA_W_ACK, 8'($urandom_range(255)));
      return;
    end

    if (one_in(25)) begin
      add_event(BUS_SLA_R_NACK, 8'($urandom_range(255)));
      return;
    end
    add_event(BUS_SLA_R_ACK, 8'($urandom_range(255)));
    for (int i = 1; i < rx; i++) begin
      if (one_in(150)) begin
        add_event(BUS_ARB_LOST, 8'($urandom_range(255)));
        return;
      end
      add_event(BUS_DATA_R_ACK, 8'($urandom_range(255)));
    end
    add_event(BUS_DATA_R_NACK, 8'($urandom_range(255)));
    // Now and then a stray byte arrives after the read is complete.
    if (one_in(20)) add_event(BUS_DATA_R_ACK, 8'($urandom_range(255)));
  endtask

  // Most gaps are short or absent, a few are long. Now and then a calm
  // stretch with no gaps at all begins.
  function automatic int pick_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(99);
    if (r == 0) begin
      calm = $urandom_range(30, 80);
      return 0;
    end
    if (r < 65) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Input driver. This runs on the falling edge. Valid and payload are held
  // until the transaction is seen accepted at a rising edge. Only then is a
  // gap inserted or the next pending transaction presented.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_taken)) begin
      in_taken = 1'b0;
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (pending_items.size() != 0 &&
                   !(pending_hold[0] && awaited_results.size() != 0)) begin
        in_item  <= pending_items.pop_front();
        in_valid <= 1'b1;
        pending_hold.delete(0);
        in_gap = pick_gap(in_calm);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result side back-pressure. This is independent of out_valid, so that
  // stalls fall on every phase of the pipeline.
  always @(negedge clk) begin
    if (out_gap > 0) begin
      out_gap--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      out_gap = pick_gap(out_calm);
    end
  end

  // --------------------------------------------------------------------------
  // Monitor. This runs on the rising edge. An accepted input transaction is
  // predicted before the result port is checked, so the order of the
  // expectations always follows the order of acceptance. The same block
  // also keeps the hang watchdog.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        awaited_results.push_back(transfer_actions(in_item));
        accepted_total++;
        in_taken = 1'b1;
      end
      if (out_valid && out_ready) begin
        if (awaited_results.size() == 0) begin
          $error("result transaction arrived with none awaited");
          mismatches++;
        end else begin
          want = awaited_results.pop_front();
          check_field("data_valid",  8'(want.data_valid),  8'(out_item.data_valid));
          check_field("data_out",    want.data_out,        out_item.data_out);
          check_field("clear_start", 8'(want.clear_start), 8'(out_item.clear_start));
          check_field("set_start",   8'(want.set_start),   8'(out_item.set_start));
          check_field("set_stop",    8'(want.set_stop),    8'(out_item.set_stop));
          check_field("ack_valid",   8'(want.ack_valid),   8'(out_item.ack_valid));
          check_field("ack_assert",  8'(want.ack_assert),  8'(out_item.ack_assert));
          check_field("rx_valid",    8'(want.rx_valid),    8'(out_item.rx_valid));
          check_field("rx_byte",     want.rx_byte,         out_item.rx_byte);
          check_field("rx_index",    want.rx_index,        out_item.rx_index);
          check_field("status",      8'(want.status),      8'(out_item.status));
          check_field("done_res",    8'(want.done_res),    8'(out_item.done_res));
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus build, reset and end of test.
  // --------------------------------------------------------------------------
  initial begin
    in_item_t noise;
    int       directed_count;

    // Events with no transfer started: the address ACK finds nothing to
    // write, and the data ACK finds nothing to read, so it stops cleanly.
    add_event(BUS_SLA_W_ACK, 8'h00);
    add_event(BUS_DATA_W_ACK, 8'hFF);
    // The unused kind, with every bit of every field set.
    push_item('1);

    // Write two bytes, then read two. This includes a spurious address ACK
    // after the writes and a stray byte once the read is over.
    add_load(4'd0, 8'hFF);
    add_load(4'd1, 8'h00);
    add_start(8'hFE, 5'd2, 8'd2, 1'b1);
    add_event(BUS_START, 8'h00);
    add_event(BUS_SLA_W_ACK, 8'hFF);
    add_event(BUS_DATA_W_ACK, 8'h00);
    add_event(BUS_SLA_W_ACK, 8'hFF);
    add_event(BUS_DATA_W_ACK, 8'h00);
    add_event(BUS_RESTART, 8'hFF);
    add_event(BUS_SLA_R_ACK, 8'h00);
    add_event(BUS_DATA_R_ACK, 8'hFF);
    add_event(BUS_DATA_R_NACK, 8'h00);
    add_event(BUS_DATA_R_ACK, 8'hA5);

    // A read-only transfer at the largest read count, refused at the address.
    add_start(8'h00, 5'd0, 8'd255, 1'b1);
    add_event(BUS_START, 8'h5A);
    add_event(BUS_SLA_R_NACK, 8'h5A);

    // The largest write count is clipped to the store depth. This transfer
    // only sends its address before a fresh start replaces it, so no store
    // entry is read and none needs loading first.
    add_start(8'h7E, 5'd31, 8'd0, 1'b0);
    add_event(BUS_START, 8'hC3);
    add_start(8'h81, 5'd0, 8'd0, 1'b1);
    add_event(BUS_SLA_W_NACK, 8'h3C);
    add_event(BUS_DATA_W_NACK, 8'h3C);
    add_event(BUS_ARB_LOST, 8'h0F);
    add_event(8'h00, 8'hF0);
    add_event(8'hFF, 8'h0F);
    directed_count = pending_items.size();

    // The first random transaction waits for the directed results to drain.
    hold_next = 1'b1;
    while (pending_items.size() < directed_count + STIM_ITEMS) begin
      if (one_in(6)) begin
        // Noise: random kinds and codes, in no particular order. About half
        // of the events use one of the engine's real status codes, which are
        // the multiples of eight from START to the final read NACK.
        repeat ($urandom_range(1, 4)) begin
          noise = any_item();
          case (noise.kind)
            KIND_START: add_start(noise.slave_addr, noise.tx_count, noise.rx_count, 1'b1);
            KIND_LOAD:  add_load(noise.load_index, noise.load_byte);
            default: begin
              if (noise.kind == KIND_EVENT && one_in(2))
                noise.bus_status = 8'(BUS_START * $urandom_range(1, 11));
              push_item(noise);
            end
          endcase
        end
      end else begin
        add_transfer();
      end
    end
    stim_total = pending_items.size();

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // The test ends once every transaction has been accepted and every
    // result collected. The result port is then watched a little longer for
    // any stray result transactions.
    while (accepted_total != stim_total || awaited_results.size() != 0)
      @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ files.f @@
design/i2cmts_pkg.sv
design/i2cmts_wstore.sv
design/i2cmts_ctrl.sv
design/i2c_master_transfer_sequencer.sv
bench/tb_i2c_master_transfer_sequencer.sv
